// ===== rtl/core/swrm_pkg.sv =====
// shared types and constants for the stack with running median
// no dependencies
package swrm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int RESULT_BITS = 16;
    // one spare cell per chain: an insert may run the lower half one over
    // its share until the rebalance step moves its head across
    localparam int HALF_DEPTH  = STACK_DEPTH / 2 + 1;
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int HALF_BITS   = $clog2(HALF_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_PUSH_FRONT,
        CELL_POP_FRONT
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [VALUE_BITS-1:0] key;
    } chain_ctrl_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  valid;
        logic                  flag;
    } cell_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_BALANCE
    } state_t;

endpackage

// ===== rtl/core/swrm_cell.sv =====
// one cell of a sorted chain: a value, its valid bit and the local shift rule
// depends on swrm_pkg
module swrm_cell
    import swrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  logic        descending,
    input  cell_link_t  left,
    input  cell_link_t  right,
    output cell_link_t  self
);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  valid_reg, valid_next;
    logic                  flag;

    // out-of-order flag, true from the place of change to the tail
    always_comb
    begin
        case (ctrl.op)
            CELL_INSERT:
                flag = !valid_reg || (descending ? (value_reg < ctrl.key)
                                                 : (value_reg > ctrl.key));
            CELL_DELETE:
                flag = !valid_reg || (descending ? (value_reg <= ctrl.key)
                                                 : (value_reg >= ctrl.key));
            default:
                flag = 1'b0;
        endcase
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (flag)
                begin
                    value_next = left.flag ? left.value : ctrl.key;
                    valid_next = valid_reg | left.valid;
                end
            end
            CELL_DELETE:
            begin
                if (flag)
                begin
                    value_next = right.value;
                    valid_next = right.valid;
                end
            end
            CELL_PUSH_FRONT:
            begin
                value_next = left.value;
                valid_next = left.valid;
            end
            CELL_POP_FRONT:
            begin
                value_next = right.value;
                valid_next = right.valid;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign self = '{value: value_reg, valid: valid_reg, flag: flag};

endmodule

// ===== rtl/core/swrm_chain.sv =====
// row of sorted cells with its head at cell zero
// depends on swrm_pkg and swrm_cell
module swrm_chain
    import swrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chain_ctrl_t           ctrl,
    input  logic                  descending,
    output logic [VALUE_BITS-1:0] head_value
);

    cell_link_t links [HALF_DEPTH];
    cell_link_t head_in;
    cell_link_t tail_in;

    // before the head: the key, valid, never out of order
    assign head_in = '{value: ctrl.key, valid: 1'b1, flag: 1'b0};
    assign tail_in = '{value: links[HALF_DEPTH-1].value, valid: 1'b0, flag: 1'b1};

    for (genvar i = 0; i < HALF_DEPTH; i++)
    begin : g_cell
        cell_link_t left_link;
        cell_link_t right_link;

        if (i == 0)
        begin : g_first
            assign left_link = head_in;
        end
        else
        begin : g_mid_left
            assign left_link = links[i-1];
        end

        if (i == HALF_DEPTH - 1)
        begin : g_last
            assign right_link = tail_in;
        end
        else
        begin : g_mid_right
            assign right_link = links[i+1];
        end

        swrm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .descending (descending),
            .left       (left_link),
            .right      (right_link),
            .self       (links[i])
        );
    end

    assign head_value = links[0].value;

endmodule

// ===== rtl/core/stack_with_running_median_unit.sv =====
// top level: lifo stack with lower-median query
// depends on swrm_pkg and swrm_chain
// push: insert, then rebalance, no result item; a push to a full stack is dropped
// pop: stack memory read, chain delete, rebalance; result registered by the chain delete step
// peek and empty pop: result in the output register in the cycle after accept
// rate is set by the single sequencer walking the stack memory read and the two chain updates
// reset clears cell valid bits, counts and handshake state; stack memory is not cleared
module stack_with_running_median_unit
    import swrm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic [VALUE_BITS-1:0]  push_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RESULT_BITS-1:0] result_value,
    output logic                   invalid
);

    // the sorted store is split in two chains: the lower half kept descending
    // (its head is the lower median) and the upper half kept ascending
    // (its head is the smallest of the upper values); lower holds ceil(n/2)

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [HALF_BITS-1:0]   lo_count_reg, lo_count_next;
    logic [HALF_BITS-1:0]   up_count_reg, up_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [RESULT_BITS-1:0] result_reg, result_next;
    logic                   invalid_reg, invalid_next;

    chain_ctrl_t            lo_ctrl, up_ctrl;
    logic [VALUE_BITS-1:0]  lo_head, up_head;

    // stack memory
    logic [VALUE_BITS-1:0]  stack_mem [STACK_DEPTH];
    logic [VALUE_BITS-1:0]  rd_data_reg;
    logic                   mem_we, mem_re;
    logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
    logic [CNT_BITS-1:0]    top_index;

    logic                   accept;
    logic                   empty;
    logic [HALF_BITS:0]     lo_wide, up_wide;

    assign top_index = count_reg - CNT_BITS'(1);
    assign wr_addr   = count_reg[ADDR_BITS-1:0];
    assign rd_addr   = top_index[ADDR_BITS-1:0];
    assign empty     = (count_reg == '0);
    assign lo_wide   = {1'b0, lo_count_reg};
    assign up_wide   = {1'b0, up_count_reg};

    // take a new item only when idle and the output slot is free or draining
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    swrm_chain u_lower (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lo_ctrl),
        .descending (1'b1),
        .head_value (lo_head)
    );

    swrm_chain u_upper (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (up_ctrl),
        .descending (1'b0),
        .head_value (up_head)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_count_next  = lo_count_reg;
        up_count_next  = up_count_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        invalid_next   = invalid_reg;
        lo_ctrl        = '{op: CELL_HOLD, key: push_value};
        up_ctrl        = '{op: CELL_HOLD, key: push_value};
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        // result item taken downstream
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_PUSH:
                        begin
                            // full stack drops the push
                            if (count_reg < CNT_BITS'(STACK_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_BITS'(1);
                                if (lo_count_reg == '0 || push_value <= lo_head)
                                begin
                                    lo_ctrl.op    = CELL_INSERT;
                                    lo_count_next = lo_count_reg + HALF_BITS'(1);
                                end
                                else
                                begin
                                    up_ctrl.op    = CELL_INSERT;
                                    up_count_next = up_count_reg + HALF_BITS'(1);
                                end
                                state_next = ST_BALANCE;
                            end
                        end
                        CMD_POP:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                result_next    = '0;
                                invalid_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_REMOVE;
                            end
                        end
                        CMD_PEEK:
                        begin
                            out_valid_next = 1'b1;
                            result_next    = empty ? '0 : RESULT_BITS'(lo_head);
                            invalid_next   = empty;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REMOVE:
            begin
                // popped value is in rd_data_reg; drop one copy from its half
                out_valid_next = 1'b1;
                result_next    = RESULT_BITS'(rd_data_reg);
                invalid_next   = 1'b0;
                count_next     = count_reg - CNT_BITS'(1);
                lo_ctrl.key    = rd_data_reg;
                up_ctrl.key    = rd_data_reg;
                if (rd_data_reg <= lo_head)
                begin
                    lo_ctrl.op    = CELL_DELETE;
                    lo_count_next = lo_count_reg - HALF_BITS'(1);
                end
                else
                begin
                    up_ctrl.op    = CELL_DELETE;
                    up_count_next = up_count_reg - HALF_BITS'(1);
                end
                state_next = ST_BALANCE;
            end
            ST_BALANCE:
            begin
                // keep lower at up+0 or up+1 entries by moving one head across
                if (lo_wide > up_wide + (HALF_BITS+1)'(1))
                begin
                    lo_ctrl.op    = CELL_POP_FRONT;
                    up_ctrl.op    = CELL_PUSH_FRONT;
                    up_ctrl.key   = lo_head;
                    lo_count_next = lo_count_reg - HALF_BITS'(1);
                    up_count_next = up_count_reg + HALF_BITS'(1);
                end
                else if (up_wide > lo_wide)
                begin
                    up_ctrl.op    = CELL_POP_FRONT;
                    lo_ctrl.op    = CELL_PUSH_FRONT;
                    lo_ctrl.key   = up_head;
                    up_count_next = up_count_reg - HALF_BITS'(1);
                    lo_count_next = lo_count_reg + HALF_BITS'(1);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lo_count_reg  <= '0;
            up_count_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_count_reg  <= lo_count_next;
            up_count_reg  <= up_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        invalid_reg <= invalid_next;
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[wr_addr] <= push_value;
        if (mem_re)
            rd_data_reg <= stack_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign invalid      = invalid_reg;

endmodule

// ===== rtl/core/swrm_checker.sv =====
// port-level assertions for the stack with running median, bound to the top level
// depends on swrm_pkg and stack_with_running_median_unit
module swrm_checker
    import swrm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [1:0]             command,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [RESULT_BITS-1:0] result_value,
    input logic                   invalid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(invalid))
        else $error("result item changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> result_value == '0)
        else $error("invalid result item carries a nonzero value");

    a_push_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_PUSH |=> !out_valid)
        else $error("push produced a result item");

    a_peek_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_PEEK |=> out_valid)
        else $error("peek gave no result item");

    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("input taken while output slot blocked");

endmodule

bind stack_with_running_median_unit swrm_checker u_swrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .invalid      (invalid)
);
